// File: hdl/tfr_pkg.sv
package tfr_pkg;

   localparam int CSR_INDEX_W = 3;

   localparam logic [CSR_INDEX_W-1:0] CSR_START_BYTE    = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SETPOINT_TYPE = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPEED_TYPE    = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_MODE_TYPE     = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_AUTO_MODE     = 3'd4;

   localparam logic [1:0] EV_GOOD     = 2'd0;
   localparam logic [1:0] EV_BAD_LEN  = 2'd1;
   localparam logic [1:0] EV_BAD_CSUM = 2'd2;

   localparam logic [7:0] RESET_START_BYTE    = 8'd170;
   localparam logic [7:0] RESET_SETPOINT_TYPE = 8'd1;
   localparam logic [7:0] RESET_SPEED_TYPE    = 8'd2;
   localparam logic [7:0] RESET_MODE_TYPE     = 8'd3;
   localparam logic [7:0] RESET_AUTO_MODE     = 8'd1;

   typedef struct packed {
      logic [7:0] start_byte;
      logic [7:0] setpoint_type_id;
      logic [7:0] speed_type_id;
      logic [7:0] mode_type_id;
      logic [7:0] auto_mode_code;
   } cfg_type;

   typedef struct packed {
      logic [7:0] rx_byte;
   } req_payload_type;

   typedef struct packed {
      logic [1:0]  frame_event;
      logic [7:0]  frame_type;
      logic [6:0]  payload_length;
      logic [31:0] setpoint_bits;
      logic [31:0] speed_bits;
      logic [7:0]  mode_value;
      logic        drive_cut;
      logic        failsafe_kick;
      logic [31:0] good_count;
      logic [31:0] error_count;
   } rsp_payload_type;

   typedef struct packed {
      logic [CSR_INDEX_W-1:0] reg_index;
      logic [7:0]             wr_data;
   } csr_payload_type;

endpackage

// File: hdl/tfr_channels.sv
interface tfr_req_if;
   import tfr_pkg::*;
   logic            valid;
   logic            ready;
   req_payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface tfr_rsp_if;
   import tfr_pkg::*;
   logic            valid;
   logic            ready;
   rsp_payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface tfr_csr_if;
   import tfr_pkg::*;
   logic            valid;
   logic            ready;
   csr_payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// File: hdl/typed_frame_receiver.sv
// typed_frame_receiver
// byte-serial deframer for start / length (16-bit little-endian) / type /
// payload / xor checksum frames
// req_chan: one received byte per request; rsp_chan: one result per frame
// that ends, good or bad; csr_chan: register writes, always ready
// throughput: one byte per clock unless a byte that may end a frame waits; the
// parse state and all word updates are worked out in the cycle a byte is taken
// latency: the result for the byte that closes a frame (high length byte on
// a length error, checksum byte otherwise) is valid the next cycle
// results sit in a single output register; bytes that cannot end a frame are
// taken even while a result waits, a byte that may end a frame waits until
// the output register is free or drained in the same cycle
// reset: parser back to hunting for the start byte, setpoint, speed, mode
// and both counters cleared, registers back to their defaults, no result
// pending
module typed_frame_receiver #(
   parameter int MAX_PAYLOAD = 64
) (
   input logic      clock,
   input logic      reset,
   tfr_req_if.sink  req_chan,
   tfr_rsp_if.source rsp_chan,
   tfr_csr_if.sink  csr_chan
);
   import tfr_pkg::*;

   cfg_type         cfg;
   logic            in_fire;
   logic            may_emit;
   logic            emit;
   logic            slot_free;
   rsp_payload_type result;

   assign req_chan.ready = slot_free || !may_emit;
   assign in_fire = req_chan.valid && req_chan.ready;

   tfr_csr_regs u_csr (
      .clock      (clock),
      .reset      (reset),
      .wr_valid   (csr_chan.valid),
      .wr_payload (csr_chan.payload),
      .wr_ready   (csr_chan.ready),
      .cfg        (cfg)
   );

   tfr_parser #(
      .MAX_PAYLOAD (MAX_PAYLOAD)
   ) u_parser (
      .clock    (clock),
      .reset    (reset),
      .in_fire  (in_fire),
      .rx_byte  (req_chan.payload.rx_byte),
      .cfg      (cfg),
      .may_emit (may_emit),
      .emit     (emit),
      .result   (result)
   );

   tfr_out_stage u_out (
      .clock       (clock),
      .reset       (reset),
      .load        (emit),
      .load_data   (result),
      .slot_free   (slot_free),
      .rsp_valid   (rsp_chan.valid),
      .rsp_payload (rsp_chan.payload),
      .rsp_ready   (rsp_chan.ready)
   );

endmodule

// File: hdl/tfr_csr_regs.sv
module tfr_csr_regs (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     wr_valid,
   input  tfr_pkg::csr_payload_type wr_payload,
   output logic                     wr_ready,
   output tfr_pkg::cfg_type         cfg
);
   import tfr_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign wr_ready = 1'b1;
   assign cfg = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_valid) begin
         case (wr_payload.reg_index)
            CSR_START_BYTE: begin
               cfg_in.start_byte = wr_payload.wr_data;
            end
            CSR_SETPOINT_TYPE: begin
               cfg_in.setpoint_type_id = wr_payload.wr_data;
            end
            CSR_SPEED_TYPE: begin
               cfg_in.speed_type_id = wr_payload.wr_data;
            end
            CSR_MODE_TYPE: begin
               cfg_in.mode_type_id = wr_payload.wr_data;
            end
            CSR_AUTO_MODE: begin
               cfg_in.auto_mode_code = wr_payload.wr_data;
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_byte       <= RESET_START_BYTE;
         cfg_ff.setpoint_type_id <= RESET_SETPOINT_TYPE;
         cfg_ff.speed_type_id    <= RESET_SPEED_TYPE;
         cfg_ff.mode_type_id     <= RESET_MODE_TYPE;
         cfg_ff.auto_mode_code   <= RESET_AUTO_MODE;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// File: hdl/tfr_parser.sv
module tfr_parser #(
   parameter int MAX_PAYLOAD = 64
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_fire,
   input  logic [7:0]               rx_byte,
   input  tfr_pkg::cfg_type         cfg,
   output logic                     may_emit,
   output logic                     emit,
   output tfr_pkg::rsp_payload_type result
);
   import tfr_pkg::*;

   localparam int LEN_W  = $clog2(MAX_PAYLOAD + 2);
   localparam int PLEN_W = (LEN_W > 7) ? LEN_W : 7;

   localparam logic [2:0] PH_WAIT    = 3'd0;
   localparam logic [2:0] PH_LEN_LO  = 3'd1;
   localparam logic [2:0] PH_LEN_HI  = 3'd2;
   localparam logic [2:0] PH_TYPE    = 3'd3;
   localparam logic [2:0] PH_PAYLOAD = 3'd4;
   localparam logic [2:0] PH_CHECK   = 3'd5;

   logic [2:0]       phase_ff, phase_in;
   logic [7:0]       len_lo_ff, len_lo_in;
   logic [LEN_W-1:0] len_ff, len_in;
   logic [7:0]       type_ff, type_in;
   logic [LEN_W-1:0] seen_ff, seen_in;
   logic [7:0]       xor_ff, xor_in;
   logic [31:0]      four_ff, four_in;
   logic [31:0]      setpoint_ff, setpoint_in;
   logic [31:0]      speed_ff, speed_in;
   logic [7:0]       mode_ff, mode_in;
   logic [31:0]      good_ff, good_in;
   logic [31:0]      err_ff, err_in;

   logic [16:0]       full_len;
   logic              len_bad;
   logic [PLEN_W-1:0] plen_wide;
   logic              plen_is_four;
   logic              plen_is_one;
   logic [LEN_W-1:0]  seen_next;
   logic [7:0]        xor_next;

   assign full_len     = {1'b0, rx_byte, len_lo_ff};
   assign len_bad      = (full_len == 17'd0) || (full_len > 17'(MAX_PAYLOAD + 1));
   assign plen_wide    = PLEN_W'(len_ff) - PLEN_W'(1);
   assign plen_is_four = (len_ff == LEN_W'(5));
   assign plen_is_one  = (len_ff == LEN_W'(2));
   assign seen_next    = seen_ff + LEN_W'(1);
   assign xor_next     = xor_ff ^ rx_byte;
   assign may_emit     = (phase_ff == PH_LEN_HI) || (phase_ff == PH_CHECK);

   always_comb begin
      phase_in    = phase_ff;
      len_lo_in   = len_lo_ff;
      len_in      = len_ff;
      type_in     = type_ff;
      seen_in     = seen_ff;
      xor_in      = xor_ff;
      four_in     = four_ff;
      setpoint_in = setpoint_ff;
      speed_in    = speed_ff;
      mode_in     = mode_ff;
      good_in     = good_ff;
      err_in      = err_ff;
      emit        = 1'b0;
      result.frame_event    = EV_GOOD;
      result.frame_type     = type_ff;
      result.payload_length = plen_wide[6:0];
      result.drive_cut      = 1'b0;
      result.failsafe_kick  = 1'b0;
      if (in_fire) begin
         case (phase_ff)
            PH_WAIT: begin
               if (rx_byte == cfg.start_byte) begin
                  xor_in   = 8'd0;
                  four_in  = 32'd0;
                  phase_in = PH_LEN_LO;
               end
            end
            PH_LEN_LO: begin
               len_lo_in = rx_byte;
               xor_in    = xor_next;
               phase_in  = PH_LEN_HI;
            end
            PH_LEN_HI: begin
               xor_in = xor_next;
               if (len_bad) begin
                  err_in   = err_ff + 32'd1;
                  phase_in = PH_WAIT;
                  emit     = 1'b1;
                  result.frame_event    = EV_BAD_LEN;
                  result.frame_type     = 8'd0;
                  result.payload_length = 7'd0;
               end else begin
                  len_in   = full_len[LEN_W-1:0];
                  phase_in = PH_TYPE;
               end
            end
            PH_TYPE: begin
               type_in  = rx_byte;
               xor_in   = xor_next;
               seen_in  = '0;
               phase_in = (len_ff == LEN_W'(1)) ? PH_CHECK : PH_PAYLOAD;
            end
            PH_PAYLOAD: begin
               if (seen_ff < LEN_W'(4)) begin
                  four_in = four_ff | (32'(rx_byte) << {seen_ff[1:0], 3'b000});
               end
               seen_in = seen_next;
               xor_in  = xor_next;
               if (seen_next >= len_ff - LEN_W'(1)) begin
                  phase_in = PH_CHECK;
               end
            end
            PH_CHECK: begin
               phase_in = PH_WAIT;
               emit     = 1'b1;
               if (xor_ff != rx_byte) begin
                  err_in = err_ff + 32'd1;
                  result.frame_event = EV_BAD_CSUM;
               end else begin
                  good_in = good_ff + 32'd1;
                  result.failsafe_kick = 1'b1;
                  if (type_ff == cfg.setpoint_type_id) begin
                     if (plen_is_four) begin
                        setpoint_in = four_ff;
                     end
                  end else if (type_ff == cfg.speed_type_id) begin
                     if (plen_is_four) begin
                        speed_in = four_ff;
                     end
                  end else if (type_ff == cfg.mode_type_id) begin
                     if (plen_is_one) begin
                        mode_in = four_ff[7:0];
                        result.drive_cut = (four_ff[7:0] != cfg.auto_mode_code);
                     end
                  end
               end
            end
            default: begin
               phase_in = PH_WAIT;
            end
         endcase
      end
      result.setpoint_bits = setpoint_in;
      result.speed_bits    = speed_in;
      result.mode_value    = mode_in;
      result.good_count    = good_in;
      result.error_count   = err_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_WAIT;
         setpoint_ff <= 32'd0;
         speed_ff    <= 32'd0;
         mode_ff     <= 8'd0;
         good_ff     <= 32'd0;
         err_ff      <= 32'd0;
      end else begin
         phase_ff    <= phase_in;
         setpoint_ff <= setpoint_in;
         speed_ff    <= speed_in;
         mode_ff     <= mode_in;
         good_ff     <= good_in;
         err_ff      <= err_in;
      end
   end

   always_ff @(posedge clock) begin
      len_lo_ff <= len_lo_in;
      len_ff    <= len_in;
      type_ff   <= type_in;
      seen_ff   <= seen_in;
      xor_ff    <= xor_in;
      four_ff   <= four_in;
   end

   a_good_count_step: assert property (@(posedge clock) disable iff (reset)
      (emit && result.frame_event == EV_GOOD) |=> (good_ff == $past(good_ff) + 32'd1))
      else $error("good frame count did not advance");

   a_kick_only_good: assert property (@(posedge clock) disable iff (reset)
      emit |-> (result.failsafe_kick == (result.frame_event == EV_GOOD)))
      else $error("failsafe kick disagrees with frame event");

   a_cut_needs_mode: assert property (@(posedge clock) disable iff (reset)
      (emit && result.drive_cut) |->
         (result.frame_event == EV_GOOD && result.mode_value != cfg.auto_mode_code))
      else $error("drive cut without a non-auto mode");

endmodule

// File: hdl/tfr_out_stage.sv
module tfr_out_stage (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     load,
   input  tfr_pkg::rsp_payload_type load_data,
   output logic                     slot_free,
   output logic                     rsp_valid,
   output tfr_pkg::rsp_payload_type rsp_payload,
   input  logic                     rsp_ready
);
   import tfr_pkg::*;

   logic            valid_ff, valid_in;
   rsp_payload_type data_ff, data_in;

   assign slot_free   = !valid_ff || rsp_ready;
   assign rsp_valid   = valid_ff;
   assign rsp_payload = data_ff;

   always_comb begin
      valid_in = valid_ff && !rsp_ready;
      data_in  = data_ff;
      if (load) begin
         valid_in = 1'b1;
         data_in  = load_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      load |-> (!valid_ff || rsp_ready))
      else $error("result overwritten before it was taken");

endmodule
